### src/recf_pkg.sv
// Package holding the shared types, constants and the CRC helper of the ring echo frame checker.
package recf_pkg;

    // Default ring size, in nodes.
    localparam int MAX_RING_NODES = 64;

    // Echo frame layout and CRC constants.
    localparam logic [2:0] LED_BYTES = 3'd6;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_MSB   = 8'h80;

    // Configuration reset values.
    localparam logic [6:0] ACTIVE_NODES_RST    = 7'd64;
    localparam logic [7:0] DATA_TYPE_CODE_RST  = 8'd0;
    localparam logic [7:0] LEVEL_BIT_MASK_RST  = 8'd1;
    localparam logic [7:0] STICKY_BIT_MASK_RST = 8'd2;
    localparam logic [7:0] FAIL_THRESHOLD_RST  = 8'd3;

    // Item commands.
    typedef enum logic [2:0] {
        CMD_START      = 3'd0,
        CMD_ECHO       = 3'd1,
        CMD_ABORT      = 3'd2,
        CMD_READ_LEVEL = 3'd3,
        CMD_TAKE_PRESS = 3'd4
    } command_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ACTIVE_NODES    = 3'd0,
        CFG_DATA_TYPE_CODE  = 3'd1,
        CFG_LEVEL_BIT_MASK  = 3'd2,
        CFG_STICKY_BIT_MASK = 3'd3,
        CFG_FAIL_THRESHOLD  = 3'd4
    } cfg_index_t;

    // Input item.
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_byte;
        logic [5:0] node_index;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [7:0]  tx_sequence;
        logic        frame_done;
        logic        frame_ok;
        logic        reenumerate;
        logic        button_value;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } out_t;

    // Configuration register set.
    typedef struct packed {
        logic [6:0] active_nodes;
        logic [7:0] data_type_code;
        logic [7:0] level_bit_mask;
        logic [7:0] sticky_bit_mask;
        logic [7:0] fail_threshold;
    } cfg_t;

    // Frame close events raised by one step of the frame tracker.
    typedef struct packed {
        logic done;
        logic ok;
        logic reenum;
        logic commit;
    } frame_evt_t;

    // Requests to the node store.
    typedef struct packed {
        logic commit;
        logic query;
        logic take;
    } ns_req_t;

    // Folds one byte into the CRC-8, most significant bit first.
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/recf_node_store.sv
// Node memories: pending button bytes, committed level and press latches, commit sweep and queries.
module recf_node_store #(
    parameter int RING_NODES = recf_pkg::MAX_RING_NODES,
    localparam int NODE_W = (RING_NODES > 1) ? $clog2(RING_NODES) : 1,
    localparam int CNT_W = $clog2(RING_NODES + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  recf_pkg::ns_req_t  req,
    input  logic [NODE_W-1:0]  query_addr,
    input  logic [CNT_W-1:0]   node_count,
    input  logic               pend_we,
    input  logic [NODE_W-1:0]  pend_addr,
    input  logic [1:0]         pend_data,
    output logic               busy,
    output logic               value
);

    // Node memory entry: bit 1 press latch, bit 0 level.
    logic [1:0] node_mem [RING_NODES];
    // Pending memory entry: bit 1 sticky, bit 0 level.
    logic [1:0] pend_mem [RING_NODES];

    logic [RING_NODES-1:0] valid_reg;
    logic                 sweep_reg;
    logic                 wb_valid_reg;
    logic                 q_pend_reg;
    logic                 q_take_reg;
    logic                 rd_valid_reg;
    logic                 value_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [NODE_W-1:0]    wb_addr_reg;
    logic [1:0]           node_rd_reg;
    logic [1:0]           pend_rd_reg;

    logic                 sweep_issue;
    logic                 rd_en;
    logic [NODE_W-1:0]    rd_addr;
    logic [1:0]           node_old;
    logic                 wr_en;
    logic [1:0]           wr_data;

    // Read side: a query takes the port, otherwise the sweep walks the active nodes.
    assign sweep_issue = sweep_reg && (idx_reg < node_count);
    assign rd_en       = req.query || sweep_issue;
    assign rd_addr     = req.query ? query_addr : idx_reg[NODE_W-1:0];

    // An entry never written reads as cleared.
    assign node_old = rd_valid_reg ? node_rd_reg : 2'b00;

    // Write back: a commit copies the level and ORs in the sticky bit; a take clears the press.
    assign wr_en   = wb_valid_reg || (q_pend_reg && q_take_reg);
    assign wr_data = wb_valid_reg ? {node_old[1] | pend_rd_reg[1], pend_rd_reg[0]}
                                  : {1'b0, node_old[0]};

    assign busy  = sweep_reg || wb_valid_reg || q_pend_reg;
    assign value = value_reg;

    // Control state of the sweep and query pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            sweep_reg    <= 1'b0;
            wb_valid_reg <= 1'b0;
            q_pend_reg   <= 1'b0;
            idx_reg      <= '0;
        end else begin
            q_pend_reg   <= req.query;
            wb_valid_reg <= sweep_issue;
            if (req.commit) begin
                sweep_reg <= 1'b1;
                idx_reg   <= '0;
            end else if (sweep_issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end else begin
                sweep_reg <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[wb_addr_reg] <= 1'b1;
            end
        end
    end

    // Pipeline payload for the write-back stage and the query answer.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            wb_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (req.query) begin
            q_take_reg <= req.take;
        end
        if (q_pend_reg) begin
            value_reg <= q_take_reg ? node_old[1] : node_old[0];
        end
    end

    // Node memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wb_addr_reg] <= wr_data;
        end
        if (rd_en) begin
            node_rd_reg <= node_mem[rd_addr];
        end
    end

    // Pending memory, filled by button bytes and read by the sweep.
    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_addr] <= pend_data;
        end
        if (sweep_issue) begin
            pend_rd_reg <= pend_mem[idx_reg[NODE_W-1:0]];
        end
    end

endmodule

### src/recf_frame.sv
// Frame tracker: sequence number, byte position, header and CRC check, counters and failure streak.
module recf_frame #(
    parameter int RING_NODES = recf_pkg::MAX_RING_NODES,
    localparam int NODE_W = (RING_NODES > 1) ? $clog2(RING_NODES) : 1,
    localparam int CNT_W = $clog2(RING_NODES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  recf_pkg::in_t        item,
    input  recf_pkg::cfg_t       cfg,
    input  logic [CNT_W-1:0]     node_count,
    output recf_pkg::frame_evt_t evt,
    output logic                 pend_we,
    output logic [NODE_W-1:0]    pend_addr,
    output logic [1:0]           pend_data,
    output logic [7:0]           frame_seq,
    output logic [31:0]          good_count,
    output logic [31:0]          bad_count
);

    // Where the next echo byte falls in the frame.
    typedef enum logic [2:0] {
        POS_TYPE = 3'b001,
        POS_SEQ  = 3'b010,
        POS_BODY = 3'b100
    } pos_t;

    pos_t              stage_reg, stage_next;
    logic [7:0]        sequence_reg, sequence_next;
    logic              open_reg, open_next;
    logic              match_reg, match_next;
    logic [7:0]        crc_reg, crc_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        streak_reg, streak_next;
    logic [31:0]       good_reg, good_next;
    logic [31:0]       bad_reg, bad_next;

    logic              close_good;
    logic              close_bad;
    logic [7:0]        streak_inc;
    logic [7:0]        crc_fold_rx;

    assign crc_fold_rx = recf_pkg::crc_fold(crc_reg, item.rx_byte);
    assign streak_inc  = streak_reg + 8'd1;

    // The button byte of the current slot is reduced to its level and sticky bits.
    assign pend_addr = slot_reg[NODE_W-1:0];
    assign pend_data = {(item.rx_byte & cfg.sticky_bit_mask) != 8'h00,
                        (item.rx_byte & cfg.level_bit_mask) != 8'h00};

    // One step of the frame state for the item in hand.
    always_comb begin
        stage_next    = stage_reg;
        sequence_next = sequence_reg;
        open_next     = open_reg;
        match_next    = match_reg;
        crc_next      = crc_reg;
        slot_next     = slot_reg;
        phase_next    = phase_reg;
        streak_next   = streak_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        close_good    = 1'b0;
        close_bad     = 1'b0;
        pend_we       = 1'b0;
        evt           = '0;
        if (step) begin
            unique case (item.command)
                recf_pkg::CMD_START: begin
                    close_bad     = open_reg;
                    sequence_next = sequence_reg + 8'd1;
                    open_next     = 1'b1;
                    stage_next    = POS_TYPE;
                    match_next    = 1'b1;
                    crc_next      = 8'h00;
                    slot_next     = '0;
                    phase_next    = 3'd0;
                end
                recf_pkg::CMD_ECHO: begin
                    if (open_reg) begin
                        if (stage_reg == POS_BODY && slot_reg >= node_count) begin
                            // This byte is the CRC byte and ends the frame.
                            open_next  = 1'b0;
                            close_good = match_reg && (item.rx_byte == crc_reg);
                            close_bad  = !(match_reg && (item.rx_byte == crc_reg));
                        end else begin
                            unique case (stage_reg)
                                POS_TYPE: begin
                                    match_next = match_reg &&
                                                 (item.rx_byte == cfg.data_type_code);
                                    crc_next   = crc_fold_rx;
                                    stage_next = POS_SEQ;
                                end
                                POS_SEQ: begin
                                    match_next = match_reg && (item.rx_byte == sequence_reg);
                                    crc_next   = crc_fold_rx;
                                    stage_next = POS_BODY;
                                end
                                default: begin
                                    if (phase_reg == recf_pkg::LED_BYTES) begin
                                        // Button bytes are buffered and kept out of the CRC.
                                        pend_we    = 1'b1;
                                        phase_next = 3'd0;
                                        slot_next  = slot_reg + CNT_W'(1);
                                    end else begin
                                        crc_next   = crc_fold_rx;
                                        phase_next = phase_reg + 3'd1;
                                    end
                                end
                            endcase
                        end
                    end
                end
                recf_pkg::CMD_ABORT: begin
                    open_next = 1'b0;
                    close_bad = open_reg;
                end
                default: begin
                end
            endcase

            // Frame close bookkeeping.
            evt.done   = close_good || close_bad;
            evt.ok     = close_good;
            evt.commit = close_good;
            if (close_good) begin
                good_next   = good_reg + 32'd1;
                streak_next = 8'd0;
            end
            if (close_bad) begin
                bad_next = bad_reg + 32'd1;
                if (streak_inc >= cfg.fail_threshold) begin
                    streak_next = 8'd0;
                    evt.reenum  = 1'b1;
                end else begin
                    streak_next = streak_inc;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= POS_TYPE;
            sequence_reg <= 8'd0;
            open_reg     <= 1'b0;
            match_reg    <= 1'b0;
            crc_reg      <= 8'h00;
            slot_reg     <= '0;
            phase_reg    <= 3'd0;
            streak_reg   <= 8'd0;
            good_reg     <= 32'd0;
            bad_reg      <= 32'd0;
        end else begin
            stage_reg    <= stage_next;
            sequence_reg <= sequence_next;
            open_reg     <= open_next;
            match_reg    <= match_next;
            crc_reg      <= crc_next;
            slot_reg     <= slot_next;
            phase_reg    <= phase_next;
            streak_reg   <= streak_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
        end
    end

    assign frame_seq  = sequence_reg;
    assign good_count = good_reg;
    assign bad_count  = bad_reg;

endmodule

### src/ring_echo_frame_checker.sv
// Top level of the ring echo frame checker: configuration, item sequencing and result register.
//
//  Channel   Ports                          Direction  Payload
//  input     s_valid s_ready s_data         in         recf_pkg::in_t
//  result    m_valid m_ready m_data         out        recf_pkg::out_t
//  config    cfg_valid cfg_ready cfg_index  in         3-bit register index, 8-bit cfg_data
//
//  Start, echo, abort and unused commands pass through S_EXEC and S_DONE before the next item.
//  A node query waits in S_WAIT for the registered read and write back of the node memory.
//  The final byte of a good frame waits in S_WAIT while the commit sweeps the pending and
//  node memories one entry per cycle. Reset is synchronous and active low; no clearing pass
//  follows it. A new item is accepted while a finished result waits on m_ready.
module ring_echo_frame_checker #(
    parameter int MAX_RING_NODES = recf_pkg::MAX_RING_NODES
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  recf_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output recf_pkg::out_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_data
);

    localparam int NODE_W = (MAX_RING_NODES > 1) ? $clog2(MAX_RING_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_RING_NODES + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int IDX_W  = (CNT_W > 6) ? CNT_W : 6;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    recf_pkg::cfg_t        cfg_reg;
    recf_pkg::in_t         item_reg;
    logic                  done_reg;
    logic                  ok_reg;
    logic                  reenum_reg;
    logic                  query_reg;
    logic                  m_valid_reg;
    recf_pkg::out_t        m_data_reg;

    logic [CNT_W-1:0]      node_count;
    logic                  node_in_range;
    logic                  is_query;
    logic                  step;
    recf_pkg::frame_evt_t  evt;
    recf_pkg::ns_req_t     ns_req;
    logic                  ns_busy;
    logic                  ns_value;
    logic                  pend_we;
    logic [NODE_W-1:0]     pend_addr;
    logic [1:0]            pend_data;
    logic [7:0]            frame_seq;
    logic [31:0]           good_count;
    logic [31:0]           bad_count;
    logic                  out_load;

    // Configuration registers, written only while the block is idle.
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_nodes    <= recf_pkg::ACTIVE_NODES_RST;
            cfg_reg.data_type_code  <= recf_pkg::DATA_TYPE_CODE_RST;
            cfg_reg.level_bit_mask  <= recf_pkg::LEVEL_BIT_MASK_RST;
            cfg_reg.sticky_bit_mask <= recf_pkg::STICKY_BIT_MASK_RST;
            cfg_reg.fail_threshold  <= recf_pkg::FAIL_THRESHOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                recf_pkg::CFG_ACTIVE_NODES:    cfg_reg.active_nodes    <= cfg_data[6:0];
                recf_pkg::CFG_DATA_TYPE_CODE:  cfg_reg.data_type_code  <= cfg_data;
                recf_pkg::CFG_LEVEL_BIT_MASK:  cfg_reg.level_bit_mask  <= cfg_data;
                recf_pkg::CFG_STICKY_BIT_MASK: cfg_reg.sticky_bit_mask <= cfg_data;
                recf_pkg::CFG_FAIL_THRESHOLD:  cfg_reg.fail_threshold  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Active node count, limited to the ring size.
    assign node_count = (CMP_W'(cfg_reg.active_nodes) > CMP_W'(MAX_RING_NODES))
                        ? CNT_W'(MAX_RING_NODES) : CNT_W'(cfg_reg.active_nodes);

    // Queries go to the node store only for nodes inside the ring.
    assign node_in_range = IDX_W'(item_reg.node_index) < IDX_W'(node_count);
    assign is_query      = (item_reg.command == recf_pkg::CMD_READ_LEVEL ||
                            item_reg.command == recf_pkg::CMD_TAKE_PRESS) && node_in_range;

    assign step          = (state_reg == S_EXEC);
    assign ns_req.commit = evt.commit;
    assign ns_req.query  = step && is_query;
    assign ns_req.take   = (item_reg.command == recf_pkg::CMD_TAKE_PRESS);

    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Item sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = (evt.commit || is_query) ? S_WAIT : S_DONE;
            end
            S_WAIT: begin
                if (!ns_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item and per-item event flags.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (step) begin
            done_reg   <= evt.done;
            ok_reg     <= evt.ok;
            reenum_reg <= evt.reenum;
            query_reg  <= is_query;
        end
    end

    // Result register, decoupling the result channel from the item sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.tx_sequence  <= frame_seq;
            m_data_reg.frame_done   <= done_reg;
            m_data_reg.frame_ok     <= ok_reg;
            m_data_reg.reenumerate  <= reenum_reg;
            m_data_reg.button_value <= query_reg && ns_value;
            m_data_reg.good_frames  <= good_count;
            m_data_reg.bad_frames   <= bad_count;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    recf_frame #(
        .RING_NODES(MAX_RING_NODES)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .node_count (node_count),
        .evt        (evt),
        .pend_we    (pend_we),
        .pend_addr  (pend_addr),
        .pend_data  (pend_data),
        .frame_seq  (frame_seq),
        .good_count (good_count),
        .bad_count  (bad_count)
    );

    recf_node_store #(
        .RING_NODES(MAX_RING_NODES)
    ) u_node_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (ns_req),
        .query_addr (NODE_W'(item_reg.node_index)),
        .node_count (node_count),
        .pend_we    (pend_we),
        .pend_addr  (pend_addr),
        .pend_data  (pend_data),
        .busy       (ns_busy),
        .value      (ns_value)
    );

    // A new item is never taken while the node store is still sweeping or answering.
    assert property (@(posedge aclk) disable iff (!aresetn) s_ready |-> !ns_busy)
        else $error("item accepted while node store busy");

    // Every commit or query keeps the node store busy in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ns_req.commit || ns_req.query) |=> ns_busy)
        else $error("node store request not taken");

    // A commit only comes from the execute step of an item.
    assert property (@(posedge aclk) disable iff (!aresetn) ns_req.commit |-> step)
        else $error("commit outside execute step");

    // A reenumerate request only accompanies a frame closed as bad.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.reenumerate) |-> (m_data.frame_done && !m_data.frame_ok))
        else $error("reenumerate without a bad frame");

endmodule
